// ===== rtl/mhpq_pkg.sv =====
package mhpq_pkg;

	// defaults for the top level parameters
	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_DATA_WIDTH = 32;

	// fixed widths of the channel fields
	localparam int WORD_W  = 32;
	localparam int TOTAL_W = 7;
	localparam int ERR_W   = 2;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [TOTAL_W-1:0]       total_t;
	typedef logic [ERR_W-1:0]         err_t;

	// error codes
	localparam err_t ERR_OK    = 2'd0;
	localparam err_t ERR_FULL  = 2'd1;
	localparam err_t ERR_EMPTY = 2'd2;

	// operation codes
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_DELETE = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic take;        // latch request word, clear error and removed value
		logic ins_begin;   // hole at first free slot, count up
		logic del_begin;   // save root, count down, hole at root
		logic err_full;
		logic err_empty;
		logic rd_parent;   // read parent of hole
		logic rd_last;     // read old last entry
		logic rd_children; // read both children of hole
		logic load_v;      // moving value from read data
		logic wr_hole;     // moving value into hole, walk ends
		logic wr_up;       // parent into hole, hole moves up
		logic wr_down;     // smaller child into hole, hole moves down
		logic out_load;    // capture response word
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_kind;
		logic full;
		logic empty;
		logic pos_zero;
		logic up_go;
		logic left_in;
		logic down_go;
	} status_t;

endpackage

// ===== rtl/mhpq_ifs.sv =====
// request channel: one operation per word
interface mhpq_req_if;
	logic              valid;
	logic              ready;
	logic              kind;
	mhpq_pkg::word_t   value;

	modport source(output valid, kind, value, input ready);
	modport sink(input valid, kind, value, output ready);
endinterface

// response channel: one result word per operation
interface mhpq_rsp_if;
	logic              valid;
	logic              ready;
	mhpq_pkg::word_t   removed_value;
	mhpq_pkg::word_t   min_value;
	mhpq_pkg::total_t  entry_total;
	logic              is_empty;
	mhpq_pkg::err_t    error_code;

	modport source(output valid, removed_value, min_value, entry_total, is_empty, error_code,
		input ready);
	modport sink(input valid, removed_value, min_value, entry_total, is_empty, error_code,
		output ready);
endinterface

// ===== rtl/mhpq_dp.sv =====
module mhpq_dp #(
	parameter int CAPACITY   = mhpq_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = mhpq_pkg::DEF_DATA_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mhpq_pkg::cmd_t      cmd,
	output mhpq_pkg::status_t   sts,
	input  logic                req_kind,
	input  mhpq_pkg::word_t     req_value,
	output mhpq_pkg::word_t     removed_value,
	output mhpq_pkg::word_t     min_value,
	output mhpq_pkg::total_t    entry_total,
	output logic                is_empty,
	output mhpq_pkg::err_t      error_code
);
	import mhpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = CW + 1;

	typedef logic signed [DATA_WIDTH-1:0] data_t;

	// heap storage
	data_t mem [CAPACITY];

	logic [CW-1:0] count_q;
	logic [AW-1:0] pos_q;
	data_t         v_q;
	data_t         root_q;
	data_t         removed_q;
	err_t          err_q;
	data_t         rd_a_q;
	data_t         rd_b_q;

	function automatic word_t to_word(input data_t d);
		return WORD_W'(d);
	endfunction

	// address arithmetic around the hole
	logic [AW-1:0] parent;
	logic [PW-1:0] left_w;
	logic [PW-1:0] right_w;
	logic [PW-1:0] count_w;
	logic          right_in;

	assign parent   = (pos_q - AW'(1)) >> 1;
	assign left_w   = PW'({pos_q, 1'b0}) + PW'(1);
	assign right_w  = left_w + PW'(1);
	assign count_w  = PW'(count_q);
	assign right_in = right_w < count_w;

	// child selection, left wins on a tie
	logic  take_left;
	logic  take_right;
	data_t best_val;
	data_t left_val;
	logic [AW-1:0] best_pos;

	always_comb begin
		take_left = rd_a_q < v_q;
		left_val  = take_left ? rd_a_q : v_q;
		take_right = right_in && (rd_b_q < left_val);
		best_val  = take_right ? rd_b_q : rd_a_q;
		best_pos  = take_right ? right_w[AW-1:0] : left_w[AW-1:0];
	end

	assign sts.req_kind = req_kind;
	assign sts.full     = count_q == CW'(CAPACITY);
	assign sts.empty    = count_q == '0;
	assign sts.pos_zero = pos_q == '0;
	assign sts.up_go    = rd_a_q > v_q;
	assign sts.left_in  = left_w < count_w;
	assign sts.down_go  = take_left || take_right;

	// single write port
	logic          wr_en;
	data_t         wr_data;
	logic [AW-1:0] ra;
	logic [AW-1:0] rb;

	always_comb begin
		wr_en   = cmd.wr_hole || cmd.wr_up || cmd.wr_down;
		wr_data = v_q;
		if (cmd.wr_up) begin
			wr_data = rd_a_q;
		end else if (cmd.wr_down) begin
			wr_data = best_val;
		end
		ra = parent;
		if (cmd.rd_last) begin
			ra = count_q[AW-1:0];
		end else if (cmd.rd_children) begin
			ra = left_w[AW-1:0];
		end
		rb = right_w[AW-1:0];
	end

	// memory with registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[pos_q] <= wr_data;
		end
		if (cmd.rd_parent || cmd.rd_last || cmd.rd_children) begin
			rd_a_q <= mem[ra];
		end
		if (cmd.rd_children) begin
			rd_b_q <= mem[rb];
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins_begin) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.del_begin) begin
			count_q <= count_q - CW'(1);
		end
	end

	// hole position, moving value, root shadow, result fields
	always_ff @(posedge clk) begin
		if (cmd.ins_begin) begin
			pos_q <= count_q[AW-1:0];
		end else if (cmd.del_begin) begin
			pos_q <= '0;
		end else if (cmd.wr_up) begin
			pos_q <= parent;
		end else if (cmd.wr_down) begin
			pos_q <= best_pos;
		end

		if (cmd.take) begin
			v_q <= DATA_WIDTH'(req_value);
		end else if (cmd.load_v) begin
			v_q <= rd_a_q;
		end

		if (wr_en && pos_q == '0) begin
			root_q <= wr_data;
		end

		if (cmd.del_begin) begin
			removed_q <= root_q;
		end else if (cmd.take) begin
			removed_q <= '0;
		end

		if (cmd.err_full) begin
			err_q <= ERR_FULL;
		end else if (cmd.err_empty) begin
			err_q <= ERR_EMPTY;
		end else if (cmd.take) begin
			err_q <= ERR_OK;
		end

		if (cmd.out_load) begin
			removed_value <= to_word(removed_q);
			min_value     <= (count_q == '0) ? '0 : to_word(root_q);
			entry_total   <= TOTAL_W'(count_q);
			is_empty      <= count_q == '0;
			error_code    <= err_q;
		end
	end

endmodule

// ===== rtl/mhpq_ctrl.sv =====
module mhpq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  mhpq_pkg::status_t  sts,
	output mhpq_pkg::cmd_t     cmd
);
	import mhpq_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_I_RD   = 3'd1;
	localparam logic [2:0] S_I_CMP  = 3'd2;
	localparam logic [2:0] S_D_LAST = 3'd3;
	localparam logic [2:0] S_D_LOAD = 3'd4;
	localparam logic [2:0] S_D_RD   = 3'd5;
	localparam logic [2:0] S_D_CMP  = 3'd6;
	localparam logic [2:0] S_FIN    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;

	assign rsp_valid = rsp_valid_q;
	assign req_ready = state_q == S_IDLE;

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.take = 1'b1;
					if (sts.req_kind == KIND_INSERT) begin
						if (sts.full) begin
							cmd.err_full = 1'b1;
							state_d      = S_FIN;
						end else begin
							cmd.ins_begin = 1'b1;
							state_d       = S_I_RD;
						end
					end else begin
						if (sts.empty) begin
							cmd.err_empty = 1'b1;
							state_d       = S_FIN;
						end else begin
							cmd.del_begin = 1'b1;
							state_d       = S_D_LAST;
						end
					end
				end
			end
			S_I_RD: begin
				if (sts.pos_zero) begin
					cmd.wr_hole = 1'b1;
					state_d     = S_FIN;
				end else begin
					cmd.rd_parent = 1'b1;
					state_d       = S_I_CMP;
				end
			end
			S_I_CMP: begin
				if (sts.up_go) begin
					cmd.wr_up = 1'b1;
					state_d   = S_I_RD;
				end else begin
					cmd.wr_hole = 1'b1;
					state_d     = S_FIN;
				end
			end
			S_D_LAST: begin
				// the heap emptied: nothing to move
				if (sts.empty) begin
					state_d = S_FIN;
				end else begin
					cmd.rd_last = 1'b1;
					state_d     = S_D_LOAD;
				end
			end
			S_D_LOAD: begin
				cmd.load_v = 1'b1;
				state_d    = S_D_RD;
			end
			S_D_RD: begin
				if (!sts.left_in) begin
					cmd.wr_hole = 1'b1;
					state_d     = S_FIN;
				end else begin
					cmd.rd_children = 1'b1;
					state_d         = S_D_CMP;
				end
			end
			S_D_CMP: begin
				if (sts.down_go) begin
					cmd.wr_down = 1'b1;
					state_d     = S_D_RD;
				end else begin
					cmd.wr_hole = 1'b1;
					state_d     = S_FIN;
				end
			end
			S_FIN: begin
				// wait for the response register to be free
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/min_heap_priority_queue_core.sv =====
// Bounded binary min-heap priority queue.
// req channel: kind selects insert (value is stored) or delete of the minimum.
// rsp channel: one word per request with the removed value, the new minimum,
// the entry count, an empty flag and an error code (full on insert, empty on
// delete; the heap is left unchanged in both cases).
// One request is processed at a time; req.ready is high only while idle.
// An error goes straight to the response, and a delete that empties the heap
// moves nothing. An insert climbs from the first free slot toward the root, and
// a delete moves the last entry to the root and lets it sink toward a leaf. Each
// level costs a registered read of the single heap memory followed by a compare
// and one write. Once the response is loaded the block is idle again and takes
// the next request.
// The response sits in an output register; a finished request waits there
// while the sink stalls, and a new request is accepted in the meantime, but
// its result is held back until the previous word is taken.
// Reset clears the entry count and the handshake state; the heap memory itself
// is not cleared, since a slot's content is used only after it has been written.
module min_heap_priority_queue_core #(
	parameter int CAPACITY   = mhpq_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = mhpq_pkg::DEF_DATA_WIDTH
) (
	input logic        clk,
	input logic        arst_n,
	mhpq_req_if.sink   req,
	mhpq_rsp_if.source rsp
);
	import mhpq_pkg::*;

	cmd_t    cmd;
	status_t sts;

	mhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mhpq_dp #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_kind      (req.kind),
		.req_value     (req.value),
		.removed_value (rsp.removed_value),
		.min_value     (rsp.min_value),
		.entry_total   (rsp.entry_total),
		.is_empty      (rsp.is_empty),
		.error_code    (rsp.error_code)
	);

`ifndef SYNTHESIS
	// an accepted request makes the block busy
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while busy");

	// a pending response word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp.valid || rsp.ready))
		else $error("response overwritten before it was taken");

	// sift-up never moves the hole above the root
	a_up_below_root: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_up |-> !sts.pos_zero)
		else $error("sift-up step at the root");
`endif

endmodule

// ===== bench/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mhpq_pkg::*;

	localparam int HEAP_CAP    = DEF_CAPACITY;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 40;
	localparam int SHOW_MAX    = 10;

	// one response word as the block should produce it
	typedef struct {
		word_t  removed;
		word_t  minv;
		total_t total;
		logic   empty;
		err_t   err;
	} heap_word_t;

	// tracks the heap contents and the response words still owed by the block
	class heap_scoreboard;
		word_t      slots[HEAP_CAP];
		int         fill;
		heap_word_t owed[$];
		int         faults;

		function new();
			fill = 0;
			faults = 0;
		endfunction

		function void flag(string msg);
			faults++;
			if (faults <= SHOW_MAX)
				$display("%0t: %s", $realtime, msg);
		endfunction

		function void swap_slots(int a, int b);
			word_t t;
			t = slots[a];
			slots[a] = slots[b];
			slots[b] = t;
		endfunction

		// accepted request: update the heap and queue the owed word
		function void note_op(logic k, word_t v);
			heap_word_t w;
			int pos, par, lc, rc, best;
			w.removed = '0;
			w.err = ERR_OK;
			if (k == KIND_INSERT) begin
				if (fill >= HEAP_CAP) begin
					w.err = ERR_FULL;
				end else begin
					slots[fill] = v;
					pos = fill;
					fill++;
					// climb while the parent is strictly greater
					while (pos > 0) begin
						par = (pos - 1) / 2;
						if (slots[par] <= slots[pos])
							break;
						swap_slots(par, pos);
						pos = par;
					end
				end
			end else begin
				if (fill == 0) begin
					w.err = ERR_EMPTY;
				end else begin
					w.removed = slots[0];
					fill--;
					slots[0] = slots[fill];
					pos = 0;
					// descend, left child wins a tie
					forever begin
						lc = 2 * pos + 1;
						rc = lc + 1;
						best = pos;
						if (lc < fill && slots[lc] < slots[best])
							best = lc;
						if (rc < fill && slots[rc] < slots[best])
							best = rc;
						if (best == pos)
							break;
						swap_slots(pos, best);
						pos = best;
					end
				end
			end
			w.minv = (fill > 0) ? slots[0] : '0;
			w.total = total_t'(fill);
			w.empty = (fill == 0);
			owed.push_back(w);
		endfunction

		// accepted response: compare against the oldest owed word
		function void check_word(heap_word_t got);
			heap_word_t exp;
			if (owed.size() == 0) begin
				flag($sformatf("unexpected response word rm=%0d min=%0d tot=%0d", got.removed,
					got.minv, got.total));
				return;
			end
			exp = owed.pop_front();
			if (got.removed !== exp.removed || got.minv !== exp.minv ||
				got.total !== exp.total || got.empty !== exp.empty || got.err !== exp.err)
				flag($sformatf({"word mismatch: exp rm=%0d min=%0d tot=%0d empty=%0b err=%0d,",
					" got rm=%0d min=%0d tot=%0d empty=%0b err=%0d"},
					exp.removed, exp.minv, exp.total, exp.empty, exp.err,
					got.removed, got.minv, got.total, got.empty, got.err));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles;
	int   src_idle_pct;
	int   snk_idle_pct;

	heap_scoreboard board;

	mhpq_req_if req_ch();
	mhpq_rsp_if rsp_ch();

	min_heap_priority_queue_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// response side: random stalls, check on each accepted word
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		heap_word_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.removed = rsp_ch.removed_value;
			got.minv = rsp_ch.min_value;
			got.total = rsp_ch.entry_total;
			got.empty = rsp_ch.is_empty;
			got.err = rsp_ch.error_code;
			board.check_word(got);
		end
	end

	// mix of full range, small keys with many ties, and the extremes
	function automatic word_t pick_value();
		case ($urandom_range(9))
			0: return word_t'(32'h7FFF_FFFF);
			1: return word_t'(32'h8000_0000);
			2, 3, 4: return word_t'($urandom_range(15)) - word_t'(8);
			default: return word_t'($urandom);
		endcase
	endfunction

	// present one request word, return once it is accepted
	task automatic send_op(input logic k, input word_t v);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			req_ch.kind <= logic'($urandom_range(1));
			req_ch.value <= word_t'($urandom);
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= k;
		req_ch.value <= v;
		do
			@(posedge clk);
		while (!req_ch.ready);
		board.note_op(k, v);
	endtask

	// random bursts: fill past capacity, drain past empty, balanced, shallow
	task automatic run_random(input int n);
		int   sent;
		int   mode;
		int   burst;
		logic k;
		sent = 0;
		while (sent < n) begin
			mode = $urandom_range(3);
			burst = $urandom_range(20, 90);
			for (int i = 0; i < burst && sent < n; i++) begin
				case (mode)
					0: k = ($urandom_range(99) < 90) ? KIND_INSERT : KIND_DELETE;
					1: k = ($urandom_range(99) < 90) ? KIND_DELETE : KIND_INSERT;
					2: k = logic'($urandom_range(1));
					default: k = (board.fill > 3) ? KIND_DELETE : logic'($urandom_range(1));
				endcase
				send_op(k, pick_value());
				sent++;
			end
		end
	endtask

	initial begin
		board = new();
		cycles = 0;
		src_idle_pct = 21;
		snk_idle_pct = 61;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_INSERT;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty delete, extremes, ties, drain to empty
		send_op(KIND_DELETE, word_t'(32'h1234_5678));
		send_op(KIND_INSERT, word_t'(0));
		send_op(KIND_INSERT, word_t'(32'h7FFF_FFFF));
		send_op(KIND_INSERT, word_t'(32'h8000_0000));
		send_op(KIND_INSERT, word_t'(-1));
		send_op(KIND_INSERT, word_t'(1));
		send_op(KIND_INSERT, word_t'(5));
		send_op(KIND_INSERT, word_t'(5));
		send_op(KIND_INSERT, word_t'(-1));
		repeat (6) send_op(KIND_DELETE, word_t'($urandom));
		send_op(KIND_INSERT, word_t'(32'h5555_5555));
		send_op(KIND_INSERT, word_t'(32'hAAAA_AAAA));
		repeat (4) send_op(KIND_DELETE, word_t'($urandom));
		send_op(KIND_DELETE, word_t'(32'hFFFF_FFFF));

		// random part in three stall patterns
		run_random(510);
		src_idle_pct = 61;
		snk_idle_pct = 21;
		run_random(510);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		run_random(510);

		@(negedge clk);
		req_ch.valid <= 1'b0;

		// wait out the owed words, then a quiet stretch
		while (board.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (board.owed.size() != 0)
			board.flag($sformatf("%0d response words never arrived", board.owed.size()));

		if (board.faults == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
